@@ rtl/bir_pkg.sv @@
`default_nettype none

package bir_pkg;

    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 512;

    localparam int COORD_W = 9;
    localparam int PIXEL_W = 8;
    localparam int SIZE_W  = 10;
    localparam int STEP_W  = 25;
    localparam int FRAC_W  = 16;
    localparam int POS_W   = COORD_W + STEP_W;
    localparam int IPOS_W  = POS_W - FRAC_W;
    localparam int HSUM_W  = PIXEL_W + FRAC_W;
    localparam int ACC_W   = PIXEL_W + 2 * FRAC_W;

    localparam int S_TDATA_W   = 32;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = STEP_W;

    localparam int COL_LSB = 0;
    localparam int ROW_LSB = COL_LSB + COORD_W;
    localparam int PIX_LSB = ROW_LSB + COORD_W;

    localparam int SOURCE_SIZE_RST = 512;
    localparam logic [STEP_W-1:0] STEP_RST = 25'h001_0000;

    localparam logic [FRAC_W:0]  WEIGHT_ONE = 17'h1_0000;
    localparam logic [ACC_W-1:0] ROUND_HALF = 40'h00_8000_0000;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SOURCE_WIDTH  = 2'd0,
        REG_SOURCE_HEIGHT = 2'd1,
        REG_COLUMN_STEP   = 2'd2,
        REG_ROW_STEP      = 2'd3
    } cfg_reg_t;

endpackage

`default_nettype wire

@@ rtl/bilinear_image_resize.sv @@
`default_nettype none

// Grayscale bilinear resizer. Load items (tuser opcode 0) write one source pixel into the
// frame store if column and row lie inside MAX_WIDTH and MAX_HEIGHT; sample items (opcode 1)
// name a destination pixel and return one interpolated pixel. While s_tready is high the
// block takes one item per clock: the frame store is split into four banks by the parity of
// column and row, so the four neighbours of a sample come out of one bank read. Loads and
// samples pass the same pipeline in order, so a sample always sees every load accepted before
// it. s_tready drops only while the output register holds a result that is not taken. Each
// bank holds ceil(MAX_WIDTH/2) by ceil(MAX_HEIGHT/2) bytes, each rounded up to a power of two;
// the store is not cleared, so pixels must be loaded before they are sampled. Configuration is
// to be written by the user only while the block is idle; the block does not enforce it.
module bilinear_image_resize #(
    parameter int MAX_WIDTH  = bir_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bir_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [bir_pkg::S_TDATA_W-1:0]    s_tdata,   // column, row, pixel_in
    input  wire logic [bir_pkg::S_TUSER_W-1:0]    s_tuser,   // opcode
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [bir_pkg::M_TDATA_W-1:0]         m_tdata,   // pixel_out
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [bir_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [bir_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int XW         = $clog2(MAX_WIDTH);
    localparam int YW         = $clog2(MAX_HEIGHT);
    localparam int XA         = (XW > 1) ? XW - 1 : 1;
    localparam int YA         = (YW > 1) ? YW - 1 : 1;
    localparam int BANK_AW    = XA + YA;
    localparam int BANK_DEPTH = 2 ** BANK_AW;
    localparam int RST_W      = (bir_pkg::SOURCE_SIZE_RST > MAX_WIDTH) ?
                                MAX_WIDTH : bir_pkg::SOURCE_SIZE_RST;
    localparam int RST_H      = (bir_pkg::SOURCE_SIZE_RST > MAX_HEIGHT) ?
                                MAX_HEIGHT : bir_pkg::SOURCE_SIZE_RST;
    localparam int PW         = bir_pkg::PIXEL_W;
    localparam int CW         = bir_pkg::COORD_W;
    localparam int FW         = bir_pkg::FRAC_W;

    // configuration, sizes kept as last column and row in use
    logic [XW-1:0]                 src_wm1_reg;
    logic [YW-1:0]                 src_hm1_reg;
    logic [bir_pkg::STEP_W-1:0]    col_step_reg;
    logic [bir_pkg::STEP_W-1:0]    row_step_reg;
    logic [bir_pkg::SIZE_W-1:0]    cfg_size;

    logic advance;

    logic [CW-1:0] in_col;
    logic [CW-1:0] in_row;
    logic [PW-1:0] in_pix;

    // stage 1: positions
    logic                         s1_valid_reg;
    bir_pkg::op_t                 s1_op_reg;
    logic [CW-1:0]                s1_col_reg;
    logic [CW-1:0]                s1_row_reg;
    logic [PW-1:0]                s1_pix_reg;
    logic [bir_pkg::POS_W-1:0]    s1_rx_reg;
    logic [bir_pkg::POS_W-1:0]    s1_ry_reg;
    logic [bir_pkg::POS_W-1:0]    s1_rx_next;
    logic [bir_pkg::POS_W-1:0]    s1_ry_next;

    // stage 2: bank addresses
    logic [bir_pkg::IPOS_W-1:0]   ix;
    logic [bir_pkg::IPOS_W-1:0]   iy;
    logic                         x_edge;
    logic                         y_edge;
    logic [XW-1:0]                x1;
    logic [XW-1:0]                x2;
    logic [YW-1:0]                y1;
    logic [YW-1:0]                y2;
    logic                         load_in_store;

    logic                         s2_write_reg;
    logic                         s2_read_reg;
    logic                         s2_write_next;
    logic                         s2_read_next;
    logic [1:0]                   s2_wsel_reg;
    logic [1:0]                   s2_wsel_next;
    logic [PW-1:0]                s2_pix_reg;
    logic [XA-1:0]                s2_xa_reg [2];
    logic [YA-1:0]                s2_ya_reg [2];
    logic [XA-1:0]                s2_xa_next [2];
    logic [YA-1:0]                s2_ya_next [2];
    logic [1:0]                   s2_xsel_reg;
    logic [1:0]                   s2_ysel_reg;
    logic [FW-1:0]                s2_p_reg;
    logic [FW-1:0]                s2_q_reg;

    // stage 3: bank read data
    logic [PW-1:0]                bank_rd_reg [4];
    logic                         s3_valid_reg;
    logic [1:0]                   s3_xsel_reg;
    logic [1:0]                   s3_ysel_reg;
    logic [FW-1:0]                s3_p_reg;
    logic [FW-1:0]                s3_q_reg;
    logic [PW-1:0]                pix_a;
    logic [PW-1:0]                pix_b;
    logic [PW-1:0]                pix_c;
    logic [PW-1:0]                pix_d;
    logic [FW:0]                  wp0;
    logic [bir_pkg::HSUM_W-1:0]   s4_top_next;
    logic [bir_pkg::HSUM_W-1:0]   s4_bot_next;

    // stage 4: row sums
    logic                         s4_valid_reg;
    logic [bir_pkg::HSUM_W-1:0]   s4_top_reg;
    logic [bir_pkg::HSUM_W-1:0]   s4_bot_reg;
    logic [FW-1:0]                s4_q_reg;
    logic [FW:0]                  wq0;
    logic [bir_pkg::ACC_W-1:0]    s5_acc_next;

    // stage 5: weighted sum
    logic                         s5_valid_reg;
    logic [bir_pkg::ACC_W-1:0]    s5_acc_reg;
    logic [bir_pkg::ACC_W-1:0]    rounded;

    logic                         m_tvalid_reg;
    logic [PW-1:0]                m_tdata_reg;

    assign advance   = !m_tvalid_reg || m_tready;
    assign s_tready  = advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign in_col = s_tdata[bir_pkg::COL_LSB +: CW];
    assign in_row = s_tdata[bir_pkg::ROW_LSB +: CW];
    assign in_pix = s_tdata[bir_pkg::PIX_LSB +: PW];

    assign cfg_size = cfg_data[bir_pkg::SIZE_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_wm1_reg  <= XW'(RST_W - 1);
            src_hm1_reg  <= YW'(RST_H - 1);
            col_step_reg <= bir_pkg::STEP_RST;
            row_step_reg <= bir_pkg::STEP_RST;
        end else if (cfg_valid) begin
            unique case (bir_pkg::cfg_reg_t'(cfg_index))
                bir_pkg::REG_SOURCE_WIDTH: begin
                    if (cfg_size == '0) begin
                        src_wm1_reg <= '0;
                    end else if (32'(cfg_size) > MAX_WIDTH) begin
                        src_wm1_reg <= XW'(MAX_WIDTH - 1);
                    end else begin
                        src_wm1_reg <= XW'(cfg_size - bir_pkg::SIZE_W'(1));
                    end
                end
                bir_pkg::REG_SOURCE_HEIGHT: begin
                    if (cfg_size == '0) begin
                        src_hm1_reg <= '0;
                    end else if (32'(cfg_size) > MAX_HEIGHT) begin
                        src_hm1_reg <= YW'(MAX_HEIGHT - 1);
                    end else begin
                        src_hm1_reg <= YW'(cfg_size - bir_pkg::SIZE_W'(1));
                    end
                end
                bir_pkg::REG_COLUMN_STEP: col_step_reg <= cfg_data;
                bir_pkg::REG_ROW_STEP:    row_step_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1
    assign s1_rx_next = bir_pkg::POS_W'(in_col) * bir_pkg::POS_W'(col_step_reg);
    assign s1_ry_next = bir_pkg::POS_W'(in_row) * bir_pkg::POS_W'(row_step_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_op_reg  <= bir_pkg::op_t'(s_tuser[0]);
            s1_col_reg <= in_col;
            s1_row_reg <= in_row;
            s1_pix_reg <= in_pix;
            s1_rx_reg  <= s1_rx_next;
            s1_ry_reg  <= s1_ry_next;
        end
    end

    // stage 2: clamp to the source edge and pick the bank addresses
    always_comb begin
        ix     = s1_rx_reg[bir_pkg::POS_W-1:FW];
        iy     = s1_ry_reg[bir_pkg::POS_W-1:FW];
        x_edge = ix >= bir_pkg::IPOS_W'(src_wm1_reg);
        y_edge = iy >= bir_pkg::IPOS_W'(src_hm1_reg);
        x1     = x_edge ? src_wm1_reg : XW'(ix);
        x2     = x_edge ? src_wm1_reg : XW'(ix) + XW'(1);
        y1     = y_edge ? src_hm1_reg : YW'(iy);
        y2     = y_edge ? src_hm1_reg : YW'(iy) + YW'(1);

        load_in_store = (32'(s1_col_reg) < MAX_WIDTH) && (32'(s1_row_reg) < MAX_HEIGHT);
        s2_write_next = s1_valid_reg && (s1_op_reg == bir_pkg::OP_LOAD) && load_in_store;
        s2_read_next  = s1_valid_reg && (s1_op_reg == bir_pkg::OP_SAMPLE);

        if (s1_op_reg == bir_pkg::OP_LOAD) begin
            s2_xa_next[0] = XA'(s1_col_reg >> 1);
            s2_xa_next[1] = XA'(s1_col_reg >> 1);
            s2_ya_next[0] = YA'(s1_row_reg >> 1);
            s2_ya_next[1] = YA'(s1_row_reg >> 1);
        end else begin
            s2_xa_next[0] = x1[0] ? XA'(x2 >> 1) : XA'(x1 >> 1);
            s2_xa_next[1] = x1[0] ? XA'(x1 >> 1) : XA'(x2 >> 1);
            s2_ya_next[0] = y1[0] ? YA'(y2 >> 1) : YA'(y1 >> 1);
            s2_ya_next[1] = y1[0] ? YA'(y1 >> 1) : YA'(y2 >> 1);
        end
        s2_wsel_next = {s1_row_reg[0], s1_col_reg[0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_write_reg <= 1'b0;
            s2_read_reg  <= 1'b0;
        end else if (advance) begin
            s2_write_reg <= s2_write_next;
            s2_read_reg  <= s2_read_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s2_wsel_reg  <= s2_wsel_next;
            s2_pix_reg   <= s1_pix_reg;
            s2_xa_reg[0] <= s2_xa_next[0];
            s2_xa_reg[1] <= s2_xa_next[1];
            s2_ya_reg[0] <= s2_ya_next[0];
            s2_ya_reg[1] <= s2_ya_next[1];
            s2_xsel_reg  <= {x2[0], x1[0]};
            s2_ysel_reg  <= {y2[0], y1[0]};
            s2_p_reg     <= s1_rx_reg[FW-1:0];
            s2_q_reg     <= s1_ry_reg[FW-1:0];
        end
    end

    // frame store, one bank per column and row parity
    for (genvar g = 0; g < 4; g++) begin : g_bank
        localparam int BX = g % 2;
        localparam int BY = g / 2;

        logic [PW-1:0]      mem [BANK_DEPTH];
        logic [BANK_AW-1:0] addr;

        assign addr = {s2_ya_reg[BY], s2_xa_reg[BX]};

        always_ff @(posedge aclk) begin
            if (advance) begin
                if (s2_write_reg && (s2_wsel_reg == 2'(g))) begin
                    mem[addr] <= s2_pix_reg;
                end
                if (s2_read_reg) begin
                    bank_rd_reg[g] <= mem[addr];
                end
            end
        end
    end

    // stage 3: interpolate along rows
    always_comb begin
        pix_a = bank_rd_reg[{s3_ysel_reg[0], s3_xsel_reg[0]}];
        pix_b = bank_rd_reg[{s3_ysel_reg[0], s3_xsel_reg[1]}];
        pix_c = bank_rd_reg[{s3_ysel_reg[1], s3_xsel_reg[0]}];
        pix_d = bank_rd_reg[{s3_ysel_reg[1], s3_xsel_reg[1]}];
        wp0   = bir_pkg::WEIGHT_ONE - {1'b0, s3_p_reg};
        s4_top_next = bir_pkg::HSUM_W'(wp0) * bir_pkg::HSUM_W'(pix_a)
                    + bir_pkg::HSUM_W'(s3_p_reg) * bir_pkg::HSUM_W'(pix_b);
        s4_bot_next = bir_pkg::HSUM_W'(wp0) * bir_pkg::HSUM_W'(pix_c)
                    + bir_pkg::HSUM_W'(s3_p_reg) * bir_pkg::HSUM_W'(pix_d);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            s3_valid_reg <= s2_read_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            m_tvalid_reg <= s5_valid_reg;
        end
    end

    // stage 4: interpolate along the column
    assign wq0 = bir_pkg::WEIGHT_ONE - {1'b0, s4_q_reg};
    assign s5_acc_next = bir_pkg::ACC_W'(wq0) * bir_pkg::ACC_W'(s4_top_reg)
                       + bir_pkg::ACC_W'(s4_q_reg) * bir_pkg::ACC_W'(s4_bot_reg);

    // stage 5: round half up
    assign rounded = (s5_acc_reg + bir_pkg::ROUND_HALF) >> (2 * FW);

    always_ff @(posedge aclk) begin
        if (advance) begin
            s3_xsel_reg <= s2_xsel_reg;
            s3_ysel_reg <= s2_ysel_reg;
            s3_p_reg    <= s2_p_reg;
            s3_q_reg    <= s2_q_reg;
            s4_top_reg  <= s4_top_next;
            s4_bot_reg  <= s4_bot_next;
            s4_q_reg    <= s3_q_reg;
            s5_acc_reg  <= s5_acc_next;
            m_tdata_reg <= rounded[PW-1:0];
        end
    end

endmodule

`default_nettype wire
